>>> design/mftp_pkg.sv
// mftp_pkg: shared types and constants for the midi file track event parser
// no dependencies; compiled first

package mftp_pkg;

  // status and meta codes
  localparam logic [7:0] StatusMeta     = 8'hFF;
  localparam logic [7:0] StatusSysex    = 8'hF0;
  localparam logic [7:0] StatusSysexEsc = 8'hF7;
  localparam logic [7:0] MetaTempo      = 8'h51;
  localparam logic [7:0] DataMask       = 8'h7F;
  localparam logic [7:0] StatusFlag     = 8'h80;
  localparam logic [7:0] HiProgChange   = 8'hC0;
  localparam logic [7:0] HiChanPress    = 8'hD0;
  localparam logic [7:0] HiNibbleMask   = 8'hF0;

  localparam logic [2:0] VlqMaxBytes    = 3'd4;
  localparam logic [2:0] TempoBytes     = 3'd3;

  typedef enum logic [3:0] {
    PH_DELTA     = 4'd0,
    PH_STATUS    = 4'd1,
    PH_DATA1     = 4'd2,
    PH_DATA2     = 4'd3,
    PH_META_TYPE = 4'd4,
    PH_META_LEN  = 4'd5,
    PH_TEMPO     = 4'd6,
    PH_SYSEX_LEN = 4'd7,
    PH_SYSEX_OUT = 4'd8,
    PH_SKIP      = 4'd9
  } phase_e;

  typedef enum logic [1:0] {
    KIND_CHANNEL = 2'd0,
    KIND_TEMPO   = 2'd1,
    KIND_SYSEX   = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] event_tick;
    logic [7:0]  status_byte;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [23:0] tempo_us;
    logic [7:0]  sysex_byte;
    logic        sysex_last;
  } res_t;

endpackage

>>> design/mftp_if.sv
// mftp_in_if / mftp_out_if: valid/ready channels for track bytes and parsed events
// no dependencies; compiled after mftp_pkg

interface mftp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        track_start;
  logic [31:0] track_length;

  modport source (output valid, data_byte, track_start, track_length, input ready);
  modport sink   (input valid, data_byte, track_start, track_length, output ready);
endinterface

interface mftp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] event_tick;
  logic [7:0]  status_byte;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [23:0] tempo_us;
  logic [7:0]  sysex_byte;
  logic        sysex_last;

  modport source (output valid, kind, event_tick, status_byte, first_data, second_data,
                  tempo_us, sysex_byte, sysex_last, input ready);
  modport sink   (input valid, kind, event_tick, status_byte, first_data, second_data,
                  tempo_us, sysex_byte, sysex_last, output ready);
endinterface

>>> design/midi_file_track_event_parser_unit.sv
// midi_file_track_event_parser_unit: one track byte per request in, parsed events out
// a result is registered: it is valid in the cycle after the byte request that causes it is accepted
// throughput: one byte per cycle while the output is not stalled; the parse state update is a single pass per byte
// a byte is taken whenever the result register is empty or being drained
// reset (rst_ni low, async) clears the tick, running status, parse state and result valid
// depends on mftp_pkg and the interfaces in mftp_if.sv

module midi_file_track_event_parser_unit
  import mftp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  mftp_in_if.sink          req_i,
  mftp_out_if.source       res_o
);

  // parser state
  logic [31:0] tick_q, tick_d;
  logic [7:0]  run_q, run_d;
  phase_e      phase_q, phase_d;
  logic [27:0] vlq_q, vlq_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  cur_q, cur_d;
  logic [7:0]  held_q, held_d;
  logic [7:0]  meta_q, meta_d;
  logic [27:0] skip_q, skip_d;
  logic [23:0] tempo_q, tempo_d;
  logic [31:0] left_q, left_d;

  // result register
  logic        out_valid_q;
  res_t        res_q, res_d;
  logic        emit;

  logic        accept;
  logic [7:0]  b;
  logic        last;
  logic [27:0] take_val;
  logic [2:0]  take_cnt;
  logic        take_done;
  logic        do_delta;
  logic        do_data1;
  logic [7:0]  data_status;
  logic        two_byte;
  logic [27:0] skip_dec;

  // a new byte can enter while a finished result is being handed off
  assign req_i.ready = !out_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign b           = req_i.data_byte;

  always_comb begin
    tick_d  = tick_q;
    run_d   = run_q;
    phase_d = phase_q;
    vlq_d   = vlq_q;
    cnt_d   = cnt_q;
    cur_d   = cur_q;
    held_d  = held_q;
    meta_d  = meta_q;
    skip_d  = skip_q;
    tempo_d = tempo_q;
    left_d  = left_q;
    res_d       = '0;
    emit        = 1'b0;
    last        = 1'b0;
    take_val    = '0;
    take_cnt    = '0;
    take_done   = 1'b0;
    do_delta    = 1'b0;
    do_data1    = 1'b0;
    data_status = cur_q;
    two_byte    = 1'b0;
    skip_dec    = '0;

    if (accept) begin
      // a new track wipes everything, including an unfinished event
      if (req_i.track_start) begin
        tick_d  = '0;
        run_d   = '0;
        phase_d = PH_DELTA;
        vlq_d   = '0;
        cnt_d   = '0;
        cur_d   = '0;
        held_d  = '0;
        meta_d  = '0;
        skip_d  = '0;
        tempo_d = '0;
        left_d  = req_i.track_length;
      end

      // bytes outside a track are ignored
      if (left_d != '0) begin
        last   = (left_d == 32'd1);
        left_d = left_d - 32'd1;

        // variable-length quantity step, shared by delta and length fields
        take_val  = {vlq_d[20:0], b[6:0]};
        take_cnt  = cnt_d + 3'd1;
        take_done = !b[7] || (take_cnt >= VlqMaxBytes);
        skip_dec  = (skip_d != '0) ? skip_d - 28'd1 : skip_d;

        unique case (phase_d)
          PH_DELTA: begin
            do_delta = 1'b1;
          end
          PH_STATUS: begin
            if (b[7]) begin
              if (b < StatusSysex) begin
                run_d = b;
              end
              cur_d = b;
              if (b == StatusMeta) begin
                phase_d = PH_META_TYPE;
              end else if (b == StatusSysex || b == StatusSysexEsc) begin
                vlq_d   = '0;
                cnt_d   = '0;
                phase_d = PH_SYSEX_LEN;
              end else if (b < StatusSysex) begin
                phase_d = PH_DATA1;
                // track ends right after the status: both data bytes missing
                if (last) begin
                  emit              = 1'b1;
                  res_d.kind        = KIND_CHANNEL;
                  res_d.event_tick  = tick_d;
                  res_d.status_byte = b;
                end
              end else begin
                // system common / real-time: dropped
                phase_d = PH_DELTA;
              end
            end else if (run_d == '0) begin
              // no running status: the byte opens the next delta time
              phase_d  = PH_DELTA;
              do_delta = 1'b1;
            end else begin
              cur_d       = run_d;
              data_status = run_d;
              do_data1    = 1'b1;
            end
          end
          PH_DATA1: begin
            data_status = cur_d;
            do_data1    = 1'b1;
          end
          PH_DATA2: begin
            phase_d           = PH_DELTA;
            emit              = 1'b1;
            res_d.kind        = KIND_CHANNEL;
            res_d.event_tick  = tick_d;
            res_d.status_byte = cur_d;
            res_d.first_data  = held_d[6:0];
            res_d.second_data = b[6:0];
          end
          PH_META_TYPE: begin
            meta_d  = b;
            vlq_d   = '0;
            cnt_d   = '0;
            phase_d = PH_META_LEN;
          end
          PH_META_LEN: begin
            if (take_done) begin
              vlq_d = '0;
              cnt_d = '0;
              // tempo only when all three bytes lie inside the track
              if (meta_d == MetaTempo && take_val == 28'd3 && left_d >= 32'd3) begin
                tempo_d = '0;
                phase_d = PH_TEMPO;
              end else begin
                skip_d  = take_val;
                phase_d = (take_val != '0) ? PH_SKIP : PH_DELTA;
              end
            end else begin
              vlq_d = take_val;
              cnt_d = take_cnt;
            end
          end
          PH_TEMPO: begin
            tempo_d = {tempo_d[15:0], b};
            cnt_d   = take_cnt;
            if (take_cnt >= TempoBytes) begin
              vlq_d            = '0;
              cnt_d            = '0;
              phase_d          = PH_DELTA;
              emit             = 1'b1;
              res_d.kind       = KIND_TEMPO;
              res_d.event_tick = tick_d;
              res_d.tempo_us   = tempo_d;
            end
          end
          PH_SYSEX_LEN: begin
            if (take_done) begin
              vlq_d = '0;
              cnt_d = '0;
              // only a non-empty F0 sysex that fits in the track is streamed out
              if (cur_d == StatusSysex && take_val != '0 &&
                  {4'd0, take_val} <= left_d) begin
                skip_d           = take_val;
                phase_d          = PH_SYSEX_OUT;
                emit             = 1'b1;
                res_d.kind       = KIND_SYSEX;
                res_d.event_tick = tick_d;
                res_d.sysex_byte = StatusSysex;
              end else begin
                skip_d  = take_val;
                phase_d = (take_val != '0) ? PH_SKIP : PH_DELTA;
              end
            end else begin
              vlq_d = take_val;
              cnt_d = take_cnt;
            end
          end
          PH_SYSEX_OUT: begin
            skip_d = skip_dec;
            if (skip_dec == '0) begin
              phase_d = PH_DELTA;
            end
            emit             = 1'b1;
            res_d.kind       = KIND_SYSEX;
            res_d.event_tick = tick_d;
            res_d.sysex_byte = b;
            res_d.sysex_last = (skip_dec == '0);
          end
          PH_SKIP: begin
            skip_d = skip_dec;
            if (skip_dec == '0) begin
              phase_d = PH_DELTA;
            end
          end
          default: begin
            phase_d = PH_DELTA;
          end
        endcase

        // delta time byte: accumulate, and on completion advance the tick
        if (do_delta) begin
          if (take_done) begin
            tick_d  = tick_d + {4'd0, take_val};
            vlq_d   = '0;
            cnt_d   = '0;
            phase_d = PH_STATUS;
          end else begin
            vlq_d = take_val;
            cnt_d = take_cnt;
          end
        end

        // first data byte of a channel message (explicit or running status)
        if (do_data1) begin
          two_byte = ((data_status & HiNibbleMask) == HiProgChange) ||
                     ((data_status & HiNibbleMask) == HiChanPress);
          if (two_byte) begin
            phase_d           = PH_DELTA;
            emit              = 1'b1;
            res_d.kind        = KIND_CHANNEL;
            res_d.event_tick  = tick_d;
            res_d.status_byte = data_status;
            res_d.first_data  = b[6:0];
          end else begin
            held_d  = b;
            phase_d = PH_DATA2;
            // track ends before the second data byte: give it as zero
            if (last) begin
              emit              = 1'b1;
              res_d.kind        = KIND_CHANNEL;
              res_d.event_tick  = tick_d;
              res_d.status_byte = data_status;
              res_d.first_data  = b[6:0];
            end
          end
        end
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      run_q   <= '0;
      phase_q <= PH_DELTA;
      vlq_q   <= '0;
      cnt_q   <= '0;
      cur_q   <= '0;
      held_q  <= '0;
      meta_q  <= '0;
      skip_q  <= '0;
      tempo_q <= '0;
      left_q  <= '0;
    end else begin
      tick_q  <= tick_d;
      run_q   <= run_d;
      phase_q <= phase_d;
      vlq_q   <= vlq_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      held_q  <= held_d;
      meta_q  <= meta_d;
      skip_q  <= skip_d;
      tempo_q <= tempo_d;
      left_q  <= left_d;
    end
  end

  // result valid: refilled whenever the slot is free or drained this cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      out_valid_q <= accept && emit;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.kind        = res_q.kind;
  assign res_o.event_tick  = res_q.event_tick;
  assign res_o.status_byte = res_q.status_byte;
  assign res_o.first_data  = res_q.first_data;
  assign res_o.second_data = res_q.second_data;
  assign res_o.tempo_us    = res_q.tempo_us;
  assign res_o.sysex_byte  = res_q.sysex_byte;
  assign res_o.sysex_last  = res_q.sysex_last;

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking bench for midi_file_track_event_parser_unit, track bodies in,
// parsed events out, checked against an in-bench copy of the parser state
// depends on mftp_pkg, mftp_if.sv and the unit itself

module tb_top
  import mftp_pkg::*;
();

  localparam int ClkHalf     = 6;
  localparam int ResetCycles = 9;
  localparam int QuietLimit  = 2000;   // cycles with no request on either side
  localparam int RandomBytes = 880;
  localparam int DrainCycles = 4;      // result lands in the cycle after its byte
  localparam int MaxReports  = 60;

  typedef enum int {SinkOpen, SinkLight, SinkComb, SinkHeavy} sink_mode_e;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #ClkHalf clk_i = ~clk_i;

  mftp_in_if  track_req ();
  mftp_out_if event_res ();

  midi_file_track_event_parser_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (track_req),
    .res_o  (event_res)
  );

  // ---------------------------------------------------------------------------
  // parser state mirror, advanced once per accepted byte request
  // ---------------------------------------------------------------------------
  logic [31:0] track_tick  = '0;
  logic [7:0]  run_status  = '0;
  phase_e      phase       = PH_DELTA;
  logic [27:0] vlq_acc     = '0;
  logic [2:0]  vlq_len     = '0;
  logic [7:0]  cur_status  = '0;
  logic [7:0]  held_byte   = '0;
  logic [7:0]  meta_code   = '0;
  logic [27:0] remain_cnt  = '0;
  logic [23:0] tempo_acc   = '0;
  logic [31:0] body_left   = '0;

  res_t pending_events[$];   // parsed events still owed by the unit

  int mismatches     = 0;
  int events_checked = 0;
  int channel_events = 0;
  int tempo_events   = 0;
  int sysex_bytes    = 0;
  int in_track_bytes = 0;
  int tracks_sent    = 0;

  function automatic bit is_two_byte(input logic [7:0] st);
    return ((st & HiNibbleMask) == HiProgChange) || ((st & HiNibbleMask) == HiChanPress);
  endfunction

  // shift one byte into the quantity being read, 1 when it is complete
  function automatic bit vlq_shift_in(input logic [7:0] b);
    vlq_acc = {vlq_acc[20:0], b[6:0]};
    vlq_len = vlq_len + 3'd1;
    return !b[7] || (vlq_len >= VlqMaxBytes);
  endfunction

  function automatic void delta_shift_in(input logic [7:0] b);
    if (vlq_shift_in(b)) begin
      track_tick = track_tick + 32'(vlq_acc);
      vlq_acc    = '0;
      vlq_len    = '0;
      phase      = PH_STATUS;
    end
  endfunction

  function automatic void start_skip(input logic [27:0] n);
    remain_cnt = n;
    phase      = (n != 0) ? PH_SKIP : PH_DELTA;
  endfunction

  function automatic res_t channel_event(input logic [7:0] st, input logic [7:0] d1,
                                         input logic [7:0] d2);
    res_t ev;
    ev             = '0;
    ev.kind        = KIND_CHANNEL;
    ev.event_tick  = track_tick;
    ev.status_byte = st;
    ev.first_data  = d1[6:0];
    ev.second_data = d2[6:0];
    return ev;
  endfunction

  function automatic res_t sysex_event(input logic [7:0] b, input bit final_byte);
    res_t ev;
    ev            = '0;
    ev.kind       = KIND_SYSEX;
    ev.event_tick = track_tick;
    ev.sysex_byte = b;
    ev.sysex_last = final_byte;
    return ev;
  endfunction

  // advance the mirror by one byte; queues the event it causes, if any
  function automatic void predict_byte(input logic [7:0] b, input logic start,
                                       input logic [31:0] len, output bit in_track);
    res_t        ev;
    bit          emit;
    bit          last;
    bit          take_data1;
    logic [27:0] n;
    ev         = '0;
    emit       = 1'b0;
    take_data1 = 1'b0;
    in_track   = 1'b0;
    if (start) begin
      // new track drops whatever event was in flight
      track_tick = '0;
      run_status = '0;
      phase      = PH_DELTA;
      vlq_acc    = '0;
      vlq_len    = '0;
      cur_status = '0;
      held_byte  = '0;
      meta_code  = '0;
      remain_cnt = '0;
      tempo_acc  = '0;
      body_left  = len;
    end
    if (body_left == 0) return;
    in_track  = 1'b1;
    last      = (body_left == 32'd1);
    body_left = body_left - 32'd1;

    case (phase)
      PH_DELTA: delta_shift_in(b);
      PH_STATUS: begin
        if (b[7]) begin
          if (b < StatusSysex) run_status = b;
          cur_status = b;
          if (b == StatusMeta) begin
            phase = PH_META_TYPE;
          end else if (b == StatusSysex || b == StatusSysexEsc) begin
            vlq_acc = '0;
            vlq_len = '0;
            phase   = PH_SYSEX_LEN;
          end else if (b < StatusSysex) begin
            phase = PH_DATA1;
            if (last) begin
              emit = 1'b1;
              ev   = channel_event(b, 8'h00, 8'h00);
            end
          end else begin
            // system common and real-time bytes vanish
            phase = PH_DELTA;
          end
        end else if (run_status == 0) begin
          // stray data byte opens the next delta time
          phase = PH_DELTA;
          delta_shift_in(b);
        end else begin
          cur_status = run_status;
          take_data1 = 1'b1;
        end
      end
      PH_DATA1: take_data1 = 1'b1;
      PH_DATA2: begin
        phase = PH_DELTA;
        emit  = 1'b1;
        ev    = channel_event(cur_status, held_byte, b);
      end
      PH_META_TYPE: begin
        meta_code = b;
        vlq_acc   = '0;
        vlq_len   = '0;
        phase     = PH_META_LEN;
      end
      PH_META_LEN: begin
        if (vlq_shift_in(b)) begin
          n       = vlq_acc;
          vlq_acc = '0;
          vlq_len = '0;
          if (meta_code == MetaTempo && n == 28'(TempoBytes) && body_left >= 32'(TempoBytes)) begin
            tempo_acc = '0;
            phase     = PH_TEMPO;
          end else begin
            start_skip(n);
          end
        end
      end
      PH_TEMPO: begin
        tempo_acc = {tempo_acc[15:0], b};
        vlq_len   = vlq_len + 3'd1;
        if (vlq_len >= TempoBytes) begin
          vlq_acc       = '0;
          vlq_len       = '0;
          phase         = PH_DELTA;
          emit          = 1'b1;
          ev            = '0;
          ev.kind       = KIND_TEMPO;
          ev.event_tick = track_tick;
          ev.tempo_us   = tempo_acc;
        end
      end
      PH_SYSEX_LEN: begin
        if (vlq_shift_in(b)) begin
          n       = vlq_acc;
          vlq_acc = '0;
          vlq_len = '0;
          if (cur_status == StatusSysex && n != 0 && 32'(n) <= body_left) begin
            remain_cnt = n;
            phase      = PH_SYSEX_OUT;
            emit       = 1'b1;
            ev         = sysex_event(StatusSysex, 1'b0);
          end else begin
            start_skip(n);
          end
        end
      end
      PH_SYSEX_OUT: begin
        if (remain_cnt != 0) remain_cnt = remain_cnt - 28'd1;
        if (remain_cnt == 0) phase = PH_DELTA;
        emit = 1'b1;
        ev   = sysex_event(b, remain_cnt == 0);
      end
      PH_SKIP: begin
        if (remain_cnt != 0) remain_cnt = remain_cnt - 28'd1;
        if (remain_cnt == 0) phase = PH_DELTA;
      end
      default: phase = PH_DELTA;
    endcase

    if (take_data1) begin
      if (is_two_byte(cur_status)) begin
        phase = PH_DELTA;
        emit  = 1'b1;
        ev    = channel_event(cur_status, b, 8'h00);
      end else begin
        held_byte = b;
        phase     = PH_DATA2;
        // track ends before the second data byte: give it out with a zero
        if (last) begin
          emit = 1'b1;
          ev   = channel_event(cur_status, b, 8'h00);
        end
      end
    end
    if (emit) pending_events.push_back(ev);
  endfunction

  // ---------------------------------------------------------------------------
  // result side: stall pattern and checker
  // ---------------------------------------------------------------------------
  sink_mode_e sink_mode = SinkOpen;
  int         sink_hold = 0;
  int         sink_tick = 0;

  always @(negedge clk_i) begin
    if (sink_hold == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_hold = $urandom_range(40, 300);
    end else begin
      sink_hold--;
    end
    sink_tick++;
    case (sink_mode)
      SinkOpen:  event_res.ready <= 1'b1;
      SinkLight: event_res.ready <= ($urandom_range(0, 7) != 0);
      SinkComb:  event_res.ready <= ((sink_tick % 7) < 5);
      default:   event_res.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    // printing stops after a while, counting does not
    if (mismatches < MaxReports)
      $display("event %0d: %s got %0h want %0h", events_checked, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : check_events
    res_t want;
    if (rst_ni && event_res.valid && event_res.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected event, kind", 32'(event_res.kind), 32'hffff_ffff);
      end else begin
        want = pending_events.pop_front();
        if (event_res.kind !== want.kind)
          report_mismatch("kind", 32'(event_res.kind), 32'(want.kind));
        if (event_res.event_tick !== want.event_tick)
          report_mismatch("event_tick", event_res.event_tick, want.event_tick);
        if (event_res.status_byte !== want.status_byte)
          report_mismatch("status_byte", 32'(event_res.status_byte), 32'(want.status_byte));
        if (event_res.first_data !== want.first_data)
          report_mismatch("first_data", 32'(event_res.first_data), 32'(want.first_data));
        if (event_res.second_data !== want.second_data)
          report_mismatch("second_data", 32'(event_res.second_data), 32'(want.second_data));
        if (event_res.tempo_us !== want.tempo_us)
          report_mismatch("tempo_us", 32'(event_res.tempo_us), 32'(want.tempo_us));
        if (event_res.sysex_byte !== want.sysex_byte)
          report_mismatch("sysex_byte", 32'(event_res.sysex_byte), 32'(want.sysex_byte));
        if (event_res.sysex_last !== want.sysex_last)
          report_mismatch("sysex_last", 32'(event_res.sysex_last), 32'(want.sysex_last));
        case (want.kind)
          KIND_CHANNEL: channel_events++;
          KIND_TEMPO:   tempo_events++;
          default:      sysex_bytes++;
        endcase
      end
      events_checked++;
    end
  end

  // watchdog: a stuck handshake on either side ends the run
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((track_req.valid && track_req.ready) || (event_res.valid && event_res.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("no request accepted for %0d cycles", QuietLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // byte side: bursts with gaps, one request per accepted byte
  // ---------------------------------------------------------------------------
  bit steady     = 1'b0;   // no gaps at all while set
  int burst_left = 0;

  // called and returns on a falling edge; valid stays high into the next call
  task automatic send_byte(input logic [7:0] b, input logic start, input logic [31:0] len);
    bit in_track;
    if (!steady && burst_left == 0) begin
      track_req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    if (burst_left != 0) burst_left--;
    track_req.valid        <= 1'b1;
    track_req.data_byte    <= b;
    track_req.track_start  <= start;
    track_req.track_length <= len;
    do @(posedge clk_i); while (!track_req.ready);
    predict_byte(b, start, len, in_track);
    if (in_track) in_track_bytes++;
    @(negedge clk_i);
  endtask

  logic [7:0] track_body[$];
  logic [7:0] gen_status = '0;

  // append bytes of a literal, leftmost first
  function automatic void append_bytes(input logic [127:0] bytes, input int count);
    for (int i = count - 1; i >= 0; i--) track_body.push_back(bytes[8*i +: 8]);
  endfunction

  // the first byte carries track_start and the length; later lengths are don't-care
  task automatic send_track(input logic [31:0] len);
    foreach (track_body[i])
      send_byte(track_body[i], i == 0, (i == 0) ? len : $urandom());
    track_body.delete();
    tracks_sent++;
  endtask

  task automatic send_strays(input int count);
    repeat (count) send_byte(8'($urandom_range(0, 255)), 1'b0, $urandom());
  endtask

  function automatic void push_vlq(input logic [27:0] value, input int count);
    for (int i = count - 1; i >= 0; i--)
      track_body.push_back({i != 0, 7'(value >> (7 * i))});
  endfunction

  function automatic void push_delta();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)      push_vlq(28'($urandom_range(0, 127)), 1);
    else if (r < 80) push_vlq(28'($urandom_range(0, 16383)), 2);
    else if (r < 90) push_vlq(28'($urandom_range(0, 2097151)), 3);
    else if (r < 97) push_vlq(28'($urandom()), 4);
    else repeat (4) track_body.push_back(8'hFF);   // fourth byte still flags more
  endfunction

  function automatic void push_channel(input logic [7:0] st, input bit with_status);
    if (with_status) track_body.push_back(st);
    // a high-bit first data byte only makes sense after an explicit status
    if (with_status && $urandom_range(0, 9) == 0)
      track_body.push_back(8'($urandom_range(128, 255)));
    else
      track_body.push_back(8'($urandom_range(0, 127)));
    if (!is_two_byte(st))
      track_body.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                                       : 8'($urandom_range(0, 127)));
  endfunction

  function automatic logic [7:0] tempo_digit();
    int r;
    r = $urandom_range(0, 9);
    return (r < 2) ? 8'h00 : (r < 4) ? 8'hFF : 8'($urandom_range(0, 255));
  endfunction

  function automatic void push_message();
    int          r;
    int          n;
    logic [7:0]  code;
    logic [27:0] declared;
    r = $urandom_range(0, 99);
    if (r < 45 || (r < 60 && gen_status == 0)) begin
      gen_status = 8'($urandom_range(128, 239));
      push_channel(gen_status, 1'b1);
    end else if (r < 60) begin
      push_channel(gen_status, 1'b0);
    end else if (r < 68) begin
      track_body.push_back(StatusMeta);
      track_body.push_back(MetaTempo);
      track_body.push_back(8'(TempoBytes));
      repeat (3) track_body.push_back(tempo_digit());
    end else if (r < 76) begin
      // other meta events, tempo code with a wrong length among them
      code = 8'($urandom_range(0, 127));
      n    = $urandom_range(0, 4);
      if (code == MetaTempo && n == int'(TempoBytes)) n++;
      track_body.push_back(StatusMeta);
      track_body.push_back(code);
      push_vlq(28'(n), ($urandom_range(0, 4) == 0) ? 2 : 1);
      repeat (n) track_body.push_back(8'($urandom_range(0, 255)));
    end else if (r < 86) begin
      n        = $urandom_range(0, 6);
      declared = 28'(n);
      if ($urandom_range(0, 9) == 0) declared = declared + 28'($urandom_range(1, 200));
      track_body.push_back(StatusSysex);
      push_vlq(declared, (declared > 127) ? 2 : 1);
      for (int i = 0; i < n; i++)
        track_body.push_back((i == n - 1) ? StatusSysexEsc : 8'($urandom_range(0, 127)));
    end else if (r < 90) begin
      n = $urandom_range(0, 3);
      track_body.push_back(StatusSysexEsc);
      push_vlq(28'(n), 1);
      repeat (n) track_body.push_back(8'($urandom_range(0, 127)));
    end else if (r < 95) begin
      do code = 8'($urandom_range(241, 254)); while (code == StatusSysexEsc);
      track_body.push_back(code);
    end else begin
      track_body.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // note on, program change, pitch bend, poly pressure, running status, high-bit data, message cut by track end
  task automatic test_channel_messages();
    append_bytes(128'h00_90_3C_64_81_00_C5_7F_00_40_00_E0_85_F0_00_A2, 16);
    send_track(track_body.size());
  endtask

  // tempo, end-of-track meta, tempo whose bytes run past the track
  task automatic test_meta_events();
    append_bytes(128'h00_FF_51_03_07_A1_20_00_FF_2F_00_00_FF_51_03_01, 16);
    send_track(track_body.size());
  endtask

  // short sysex, escape sysex, empty sysex, sysex too long for the track
  task automatic test_sysex();
    append_bytes(128'h00_F0_02_7E_F7_00_F7_01_00_00_F0_00_00_F0_09_01, 16);
    send_track(track_body.size());
  endtask

  task automatic test_track_bounds();
    // empty track, then a byte that belongs to no track
    send_byte(8'h90, 1'b1, 32'd0);
    send_strays(1);
    // real-time byte, then a data byte with no running status
    append_bytes(128'h05_F8_00_44_90_01_02, 7);
    send_track(track_body.size());
    // endless track cut off mid message by the next track start
    append_bytes(128'h00_92_33, 3);
    send_track(32'hFFFF_FFFF);
    append_bytes(128'h00_33_81_10, 4);
    send_track(track_body.size());
    send_strays(2);
  endtask

  task automatic test_random_tracks();
    int target;
    int r;
    int cut;
    bit first;
    target = in_track_bytes + RandomBytes;
    first  = 1'b1;
    while (in_track_bytes < target) begin
      steady     = ($urandom_range(0, 4) == 0);
      gen_status = '0;
      if (first || $urandom_range(0, 24) == 0) begin
        // tick sweep: maximal deltas walk the tick through its wrap
        for (int k = 0; k < 17; k++) begin
          repeat (3) track_body.push_back(8'hFF);
          track_body.push_back(k[0] ? 8'hFF : 8'h7F);
          push_channel(8'($urandom_range(192, 223)), 1'b1);
        end
        first = 1'b0;
      end else begin
        repeat ($urandom_range(1, 12)) begin
          push_delta();
          push_message();
        end
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_track(track_body.size());
      end else if (r < 82) begin
        // short length: the tail falls outside the track
        cut = (track_body.size() - 1 < 4) ? track_body.size() - 1 : 4;
        send_track(track_body.size() - $urandom_range(1, cut));
      end else if (r < 90) begin
        // long length: the next track start lands mid event
        send_track(track_body.size() + $urandom_range(1, 6));
      end else if (r < 95) begin
        send_track($urandom() | 32'h8000_0000);
      end else if (r < 98) begin
        send_track(track_body.size());
        send_strays($urandom_range(1, 3));
      end else begin
        send_byte(track_body[0], 1'b1, 32'd0);
        track_body.delete();
        send_strays(1);
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    track_req.valid        = 1'b0;
    track_req.data_byte    = '0;
    track_req.track_start  = 1'b0;
    track_req.track_length = '0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_channel_messages();
    test_meta_events();
    test_sysex();
    test_track_bounds();
    test_random_tracks();

    track_req.valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d tracks, %0d track bytes parsed", tracks_sent, in_track_bytes);
    $display("%0d channel messages, %0d tempo changes, %0d sysex bytes checked",
             channel_events, tempo_events, sysex_bytes);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
